[design/plps_pkg.sv]
`timescale 1ns / 1ps

package plps_pkg;

  localparam int unsigned HoldWidth  = 16;
  localparam int unsigned PhaseWidth = 8;
  localparam int unsigned LimitWidth = 8;

  localparam logic [HoldWidth-1:0]  HoldMax  = '1;
  localparam logic [PhaseWidth-1:0] ShortEnd = 8'd120;
  localparam logic [PhaseWidth-1:0] LongEnd  = 8'd240;

  localparam int unsigned ShortSegs = 8;
  localparam int unsigned LongSegs  = 16;

  // Upper phase of each segment; segments alternate on and off, starting with on.
  localparam logic [PhaseWidth-1:0] SHORT_BOUND [ShortSegs] = '{
    8'd10, 8'd20, 8'd30, 8'd40, 8'd60, 8'd80, 8'd100, 8'd120
  };
  localparam logic [PhaseWidth-1:0] LONG_BOUND [LongSegs] = '{
    8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80,
    8'd100, 8'd120, 8'd140, 8'd160, 8'd180, 8'd200, 8'd220, 8'd240
  };

  typedef struct packed {
    logic led_level;
    logic long_mode;
  } tick_result_t;

  function automatic logic pattern_level(input logic long_sel,
                                         input logic [PhaseWidth-1:0] phase);
    logic level;
    logic found;
    level = 1'b1;
    found = 1'b0;
    if (long_sel) begin
      for (int i = 0; i < LongSegs; i++) begin
        if (!found && (phase <= LONG_BOUND[i])) begin
          level = ~i[0];
          found = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < ShortSegs; i++) begin
        if (!found && (phase <= SHORT_BOUND[i])) begin
          level = ~i[0];
          found = 1'b1;
        end
      end
    end
    return level;
  endfunction

endpackage

[design/plps_tick.sv]
`timescale 1ns / 1ps

module plps_tick import plps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_en_i,
  input  logic                  button_level_i,
  input  logic [LimitWidth-1:0] press_limit_i,
  output tick_result_t          result_o
);

  logic                  mode_q, mode_d;
  logic [HoldWidth-1:0]  hold_q, hold_d;
  logic                  was_pressed_q, was_pressed_d;
  logic [PhaseWidth-1:0] phase_q, phase_d;
  logic [HoldWidth-1:0]  limit_ext;
  logic                  change;
  logic [PhaseWidth-1:0] phase_inc;
  logic [PhaseWidth-1:0] phase_end;

  assign limit_ext = {{(HoldWidth-LimitWidth){1'b0}}, press_limit_i};

  always_comb begin
    mode_d        = mode_q;
    hold_d        = hold_q;
    was_pressed_d = was_pressed_q;
    change        = mode_q ? (hold_q < limit_ext) : (hold_q > limit_ext);
    if (button_level_i) begin
      if (hold_q != HoldMax) begin
        hold_d = hold_q + 1'b1;
      end
      was_pressed_d = 1'b1;
    end else if (was_pressed_q) begin
      if (change) begin
        mode_d        = ~mode_q;
        was_pressed_d = 1'b0;
      end
      hold_d = '0;
    end

    // The end of the pattern is that of the mode in force after this tick.
    phase_inc = phase_q + 1'b1;
    phase_end = mode_d ? LongEnd : ShortEnd;
    phase_d   = (phase_inc > phase_end) ? '0 : phase_inc;
  end

  assign result_o.led_level = pattern_level(mode_d, phase_d);
  assign result_o.long_mode = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= 1'b0;
      hold_q        <= '0;
      was_pressed_q <= 1'b0;
      phase_q       <= '0;
    end else if (tick_en_i) begin
      mode_q        <= mode_d;
      hold_q        <= hold_d;
      was_pressed_q <= was_pressed_d;
      phase_q       <= phase_d;
    end
  end

endmodule

[design/press_length_led_pattern_switch.sv]
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    button_level_i
// out       out_valid_o / out_ready_i  led_level_o, long_mode_o
// cfg       cfg_we_i                   cfg_wdata_i (press limit)
//
// A request enters the input register at the edge where it is accepted, and the
// tick logic loads its result into the result register at the next edge where
// the result register can take a new value.
// One request is accepted every cycle while results are being taken.
// Reset clears the mode, hold count, press flag and phase, and sets the press
// limit to 10. When a result is stalled the input register still takes one
// more request; after that the input side stalls until the result is taken.

module press_length_led_pattern_switch import plps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  button_level_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  led_level_o,
  output logic                  long_mode_o,
  input  logic                  cfg_we_i,
  input  logic [LimitWidth-1:0] cfg_wdata_i
);

  localparam logic [LimitWidth-1:0] LimitReset = 8'd10;

  logic                  in_valid_q;
  logic                  button_q;
  logic                  out_valid_q;
  logic [LimitWidth-1:0] limit_q;
  logic                  advance;
  logic                  tick_en;
  tick_result_t          tick_result;
  tick_result_t          result_q;

  // The result register can take a new value when it is empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign tick_en    = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      button_q <= button_level_i;
    end
    if (tick_en) begin
      result_q <= tick_result;
    end
  end

  plps_tick u_tick (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_en_i      (tick_en),
    .button_level_i (button_q),
    .press_limit_i  (limit_q),
    .result_o       (tick_result)
  );

  assign out_valid_o = out_valid_q;
  assign led_level_o = result_q.led_level;
  assign long_mode_o = result_q.long_mode;

endmodule

[design/plps_checker.sv]
`timescale 1ns / 1ps

module plps_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic button_level_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic led_level_o,
  input logic long_mode_o,
  input logic cfg_we_i
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(led_level_o) && $stable(long_mode_o))
    else $error("stalled result changed");

  // The input side only stalls behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled without a waiting result");

  // A request taken while the output is empty shows a result once it has passed the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |-> ##2 out_valid_o)
    else $error("result missing after accepted request");

  // A waiting request keeps its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(button_level_i))
    else $error("waiting request changed");

  // The press limit is to be written only while no request is in flight; the block does not enforce this.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_valid_i && !out_valid_o)
    else $error("press limit written while busy");

endmodule

bind press_length_led_pattern_switch plps_checker u_plps_checker (.*);
